/* rtl/mrcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcs_pkg
// Shared types and constants for the root candidate selector.
// ----------------------------------------------------------------------------
package mrcs_pkg;

	localparam int MAX_CANDIDATES_DEF = 256;

	localparam int PREF_W   = 8;
	localparam int STRAT_W  = 8;
	localparam int RSSI_W   = 13;
	localparam int SNR_W    = 12;
	localparam int ID_W     = 64;
	localparam int SCORE_W  = 15;
	localparam int INDEX_W  = 8;

	// packed input fields, lowest bit first: pref, stratum, rssi, snr, id
	localparam int ITEM_W   = PREF_W + STRAT_W + RSSI_W + SNR_W + ID_W;
	localparam int S_DATA_W = ((ITEM_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((INDEX_W + ID_W + 7) / 8) * 8;

	typedef struct packed {
		logic [ID_W-1:0]          id;
		logic signed [SNR_W-1:0]  snr;
		logic signed [RSSI_W-1:0] rssi;
		logic [STRAT_W-1:0]       stratum;
		logic [PREF_W-1:0]        pref;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]           id;
		logic signed [SCORE_W-1:0] score;
		logic [STRAT_W-1:0]        stratum;
		logic [PREF_W-1:0]         pref;
	} best_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [INDEX_W-1:0] index;
		logic               found;
	} res_t;

endpackage

/* rtl/mrcs_rank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcs_rank
// Score add and four-key ranking of one candidate against the held best.
// ----------------------------------------------------------------------------
module mrcs_rank (
	input  mrcs_pkg::item_t                  item,
	input  logic                             sig_valid,
	input  logic                             have_best,
	input  mrcs_pkg::best_t                  best,
	output logic                             take,
	output logic signed [mrcs_pkg::SCORE_W-1:0] score
);
	import mrcs_pkg::*;

	logic beats;

	// 2*rssi + snr, exact in 15 bits
	assign score = $signed({item.rssi[RSSI_W-1], item.rssi, 1'b0})
		+ $signed({{(SCORE_W-SNR_W){item.snr[SNR_W-1]}}, item.snr});

	always_comb begin
		if (item.pref != best.pref) begin
			beats = item.pref > best.pref;
		end else if (item.stratum != best.stratum) begin
			beats = item.stratum < best.stratum;
		end else if (score != best.score) begin
			beats = score > best.score;
		end else begin
			beats = item.id < best.id;
		end
	end

	assign take = sig_valid && (!have_best || beats);

endmodule

/* rtl/mrcs_track.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrcs_track
// Running best-candidate state, list position counter and result forming.
// ----------------------------------------------------------------------------
module mrcs_track #(
	parameter int MAX_CANDIDATES = mrcs_pkg::MAX_CANDIDATES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic            sig_valid,
	input  logic            last,
	input  mrcs_pkg::item_t item,
	output mrcs_pkg::res_t  res
);
	import mrcs_pkg::*;

	localparam int POS_W = $clog2(MAX_CANDIDATES + 1);
	localparam int IDX_W = $clog2(MAX_CANDIDATES);

	logic                      have_q;
	logic [POS_W-1:0]          item_pos_q;
	best_t                     best_q;
	logic [IDX_W-1:0]          best_pos_q;

	logic                      in_range;
	logic                      take;
	logic                      upd;
	logic signed [SCORE_W-1:0] score;
	logic                      have_n;
	logic [IDX_W-1:0]          pos_n;
	logic [ID_W-1:0]           id_n;
	logic [IDX_W+INDEX_W-1:0]  pos_ext;

	mrcs_rank u_rank (
		.item      (item),
		.sig_valid (sig_valid),
		.have_best (have_q),
		.best      (best_q),
		.take      (take),
		.score     (score)
	);

	assign in_range = item_pos_q < POS_W'(MAX_CANDIDATES);
	assign upd      = in_range && take;

	// post-update view, used for the result on the last beat
	assign have_n  = have_q || upd;
	assign pos_n   = upd ? item_pos_q[IDX_W-1:0] : best_pos_q;
	assign id_n    = upd ? item.id : best_q.id;
	assign pos_ext = {{INDEX_W{1'b0}}, pos_n};

	assign res.found = have_n;
	assign res.index = have_n ? pos_ext[INDEX_W-1:0] : '0;
	assign res.id    = have_n ? id_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			item_pos_q <= '0;
		end else if (fire) begin
			if (last) begin
				have_q     <= 1'b0;
				item_pos_q <= '0;
			end else begin
				have_q <= have_n;
				if (in_range) begin
					item_pos_q <= item_pos_q + POS_W'(1);
				end
			end
		end
	end

	// payload: only meaningful while have_q is set
	always_ff @(posedge clk) begin
		if (fire && upd) begin
			best_q.pref    <= item.pref;
			best_q.stratum <= item.stratum;
			best_q.score   <= score;
			best_q.id      <= item.id;
			best_pos_q     <= item_pos_q[IDX_W-1:0];
		end
	end

endmodule

/* rtl/mesh_root_candidate_select_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_root_candidate_select_top
// Picks the best root candidate of each list and reports it on the list's
// last beat.
// ----------------------------------------------------------------------------
// Path: accepted last beat -> input register -> result register -> m_tvalid.
// Throughput: one beat per cycle unless a last beat waits on a held result;
//   the single compare against the registered best sets the rate.
// Reset: arst_n clears the stage valids, the held-best flag and the position
//   counter; payload registers are not reset.
// ----------------------------------------------------------------------------
module mesh_root_candidate_select_top #(
	parameter int MAX_CANDIDATES = mrcs_pkg::MAX_CANDIDATES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// candidate stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// preference[7:0], stratum[15:8], rssi[28:16], snr[40:29],
	// node_id[104:41], zero pad above
	input  logic [mrcs_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                          s_tuser,  // sig_valid
	input  logic                          s_tlast,  // last candidate of list
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// best_index[7:0], best_node_id[71:8]
	output logic [mrcs_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tuser   // found
);
	import mrcs_pkg::*;

	// input register stage
	logic  valid_s1;
	item_t item_s1;
	logic  sig_s1;
	logic  last_s1;

	// result register
	logic  m_valid_q;
	res_t  res_q;

	res_t  res;
	logic  out_free;
	logic  go;

	// A non-last beat never needs the output slot, so it always drains.
	// A last beat drains when the result register is empty or being taken.
	assign out_free = !m_valid_q || m_tready;
	assign go       = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= s_tdata[ITEM_W-1:0];
			sig_s1  <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	mrcs_track #(
		.MAX_CANDIDATES (MAX_CANDIDATES)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (go),
		.sig_valid (sig_s1),
		.last      (last_s1),
		.item      (item_s1),
		.res       (res)
	);

	// result register: loads on a last beat, holds until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (go && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_DATA_W'({res_q.id, res_q.index});
	assign m_tuser  = res_q.found;

endmodule
